// ----- rtl/lnps_pkg.sv -----
// Shared types and constants for the last-note priority stack.
package lnps_pkg;

    // Default number of stack cells
    localparam int STACK_DEPTH_DEF = 16;

    // Field widths
    localparam int NOTE_W  = 7;
    localparam int IDX_W   = 5;
    localparam int COUNT_W = 5;

    // Event codes
    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_ALL_OFF  = 2'd2;
    localparam logic [1:0] MODE_READ     = 2'd3;

    // One input event
    typedef struct packed {
        logic [1:0]        mode;
        logic [NOTE_W-1:0] note;
        logic [IDX_W-1:0]  read_index;
    } item_t;

    // One result
    typedef struct packed {
        logic                cmd_valid;
        logic [NOTE_W-1:0]   cmd_note;
        logic                cmd_none;
        logic                cmd_gate;
        logic [COUNT_W-1:0]  held_count;
        logic [NOTE_W-1:0]   top_note;
        logic                top_valid;
        logic [NOTE_W-1:0]   read_note;
    } result_t;

    // Search token walking the cell chain
    typedef struct packed {
        logic active;
        logic found;
    } tok_t;

endpackage

// ----- rtl/lnps_cell.sv -----
// One stack cell: holds a note and compacts it when the search token passes.
module lnps_cell import lnps_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tok_t              tok_in,
    input  logic [NOTE_W-1:0] key,
    input  logic [CW-1:0]     count,
    input  logic              wr_en,
    input  logic [NOTE_W-1:0] wr_note,
    input  logic [NOTE_W-1:0] note_above,
    output logic [NOTE_W-1:0] note,
    output tok_t              tok_out
);

    tok_t              tok_reg;
    logic [NOTE_W-1:0] note_reg;
    logic              in_range;
    logic              hit;
    logic              shift;

    // First match below the count starts the compaction; later cells pull down
    assign in_range = CW'(INDEX) < count;
    assign hit      = tok_reg.active && !tok_reg.found && (note_reg == key) && in_range;
    assign shift    = tok_reg.active && (tok_reg.found || hit);

    assign tok_out.active = tok_reg.active;
    assign tok_out.found  = tok_reg.found || hit;
    assign note           = note_reg;

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // Note storage: append write or shift from the neighbor above
    always_ff @(posedge clk)
    begin
        if (wr_en && (count == CW'(INDEX)))
        begin
            note_reg <= wr_note;
        end
        else if (shift)
        begin
            note_reg <= note_above;
        end
    end

endmodule

// ----- rtl/last_note_priority_stack.sv -----
// Last-note priority stack: controller and chain of note cells.
// Note on / note off: the token crosses one cell per cycle, then append and top read;
//   done pulses after that. All off / read skip the sweep and go straight to done.
// busy drops while done shows, so the next item can be taken while the last result shows.
// Reset clears the held count, the polyphonic flag and control; stored notes
//   stay undefined until written. The receiver cannot stall a result.
module last_note_priority_stack import lnps_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FIN    = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    item_t             op_reg;
    logic [CW-1:0]     count_reg;
    logic [NOTE_W-1:0] top_reg;
    logic              poly_reg;
    logic              done_reg;
    result_t           result_reg, result_next;

    logic [NOTE_W-1:0] notes [STACK_DEPTH];
    tok_t              pass  [STACK_DEPTH];
    tok_t              inject;
    logic              take;
    logic              sweep_end;
    logic              wr_en;
    logic [RW-1:0]     rd_addr;
    logic              rd_ok;
    logic [NOTE_W-1:0] rd_val;

    assign take      = (state_reg == ST_IDLE) && start;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Token injection into the bottom cell for note on / note off
    assign inject.active = take && ((item.mode == MODE_NOTE_ON) || (item.mode == MODE_NOTE_OFF));
    assign inject.found  = 1'b0;

    assign sweep_end = (state_reg == ST_SWEEP) && pass[STACK_DEPTH-1].active;
    assign wr_en     = (state_reg == ST_UPDATE) && (op_reg.mode == MODE_NOTE_ON)
                       && (count_reg < CW'(STACK_DEPTH));

    // Cell chain
    for (genvar k = 0; k < STACK_DEPTH; k++)
    begin : g_cell
        tok_t              tin;
        logic [NOTE_W-1:0] above;

        if (k == 0)
        begin : g_first
            assign tin = inject;
        end
        else
        begin : g_rest
            assign tin = pass[k-1];
        end

        if (k == STACK_DEPTH - 1)
        begin : g_last
            assign above = notes[k];
        end
        else
        begin : g_mid
            assign above = notes[k+1];
        end

        lnps_cell #(
            .INDEX (k),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (tin),
            .key        (op_reg.note),
            .count      (count_reg),
            .wr_en      (wr_en),
            .wr_note    (op_reg.note),
            .note_above (above),
            .note       (notes[k]),
            .tok_out    (pass[k])
        );
    end

    // Single read port: requested entry in read mode, otherwise the top entry
    always_comb
    begin
        rd_val = '0;
        if (op_reg.mode == MODE_READ)
        begin
            rd_addr = RW'(op_reg.read_index);
            rd_ok   = RW'(op_reg.read_index) < RW'(count_reg);
        end
        else
        begin
            rd_addr = RW'(count_reg) - RW'(1);
            rd_ok   = (count_reg != '0);
        end
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            if (RW'(k) == rd_addr)
            begin
                rd_val = notes[k];
            end
        end
    end

    // Result assembly
    always_comb
    begin
        result_next            = '0;
        result_next.held_count = COUNT_W'(count_reg);
        result_next.top_valid  = (count_reg != '0);
        case (op_reg.mode)
            MODE_NOTE_ON:
            begin
                result_next.cmd_valid = 1'b1;
                result_next.cmd_note  = op_reg.note;
                result_next.cmd_gate  = 1'b1;
                result_next.top_note  = rd_ok ? rd_val : '0;
            end
            MODE_NOTE_OFF:
            begin
                result_next.cmd_valid = 1'b1;
                if (poly_reg)
                begin
                    result_next.cmd_note = op_reg.note;
                end
                else if (rd_ok)
                begin
                    result_next.cmd_note = rd_val;
                    result_next.cmd_gate = 1'b1;
                end
                else
                begin
                    result_next.cmd_none = 1'b1;
                end
                result_next.top_note = rd_ok ? rd_val : '0;
            end
            MODE_ALL_OFF:
            begin
                result_next.cmd_valid = 1'b1;
                result_next.cmd_none  = 1'b1;
            end
            default:
            begin
                result_next.read_note = rd_ok ? rd_val : '0;
                result_next.top_note  = (count_reg != '0) ? top_reg : '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (inject.active)
                begin
                    state_next = ST_SWEEP;
                end
                else if (take)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_FIN;
            ST_FIN:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            poly_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIN);
            if (cfg_valid && cfg_ready)
            begin
                poly_reg <= cfg_data;
            end
            if (take && (item.mode == MODE_ALL_OFF))
            begin
                count_reg <= '0;
            end
            else if (sweep_end && pass[STACK_DEPTH-1].found)
            begin
                count_reg <= count_reg - CW'(1);
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= item;
        end
        if (state_reg == ST_FIN)
        begin
            result_reg <= result_next;
            if (op_reg.mode != MODE_READ)
            begin
                top_reg <= rd_val;
            end
        end
    end

endmodule

// ----- rtl/lnps_chk.sv -----
// Port-level checks for the last-note priority stack, bound to the top level.
module lnps_chk import lnps_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // A result never shows while an item is still in work
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted item always occupies the block
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding work");

    // No command means all command fields clear
    a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.cmd_valid) |->
            (result.cmd_note == '0) && !result.cmd_none && !result.cmd_gate)
        else $error("command fields set without a command");

    // Empty stack reports a zero top note
    a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.top_valid) |-> (result.top_note == '0))
        else $error("top note set on empty stack");

endmodule

bind last_note_priority_stack lnps_chk u_lnps_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
